/* design/b2s_pkg.sv */
// Package for the BLAKE2s hash engine: payload structs, IV and message schedule.
// Used by every module of the design; depends on nothing.
`default_nettype none
package b2s_pkg;

  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        last_item;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  // Word sent from the front end to the compression back end.
  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        last_item;
    logic        first;
    logic [5:0]  digest_len;
    logic [5:0]  key_len;
  } job_t;

  localparam int unsigned RegDigestBytes = 0;
  localparam int unsigned RegKeyBytes    = 1;

  localparam logic [31:0] ParamBase = 32'h0101_0000;

  function automatic logic [31:0] iv_word(input logic [2:0] idx);
    logic [31:0] w;
    case (idx)
      3'd0: w = 32'h6a09e667;
      3'd1: w = 32'hbb67ae85;
      3'd2: w = 32'h3c6ef372;
      3'd3: w = 32'ha54ff53a;
      3'd4: w = 32'h510e527f;
      3'd5: w = 32'h9b05688c;
      3'd6: w = 32'h1f83d9ab;
      default: w = 32'h5be0cd19;
    endcase
    return w;
  endfunction

  // Message word index for round r, slot s (0..15).
  function automatic logic [3:0] sigma(input logic [3:0] r, input logic [3:0] s);
    logic [63:0] row;
    case (r)
      4'd0: row = 64'hfedcba9876543210;
      4'd1: row = 64'h357b20c16df984ae;
      4'd2: row = 64'h491763eadf250c8b;
      4'd3: row = 64'h8f04a562ebcd1397;
      4'd4: row = 64'hd386cb1efa427509;
      4'd5: row = 64'h91ef57d438b0a6c2;
      4'd6: row = 64'hb8293670a4def15c;
      4'd7: row = 64'ha2684f05931ce7bd;
      4'd8: row = 64'h5a417d2c803b9ef6;
      default: row = 64'h0dc3e9bf5167482a;
    endcase
    return row[s*4 +: 4];
  endfunction

endpackage
`default_nettype wire

/* design/b2s_front.sv */
// Front end: accepts input items and tags each with the configuration registers.
// Depends on b2s_pkg.
`default_nettype none
module b2s_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic [0:0]    cfg_idx_i,
  input  wire logic [5:0]    cfg_data_i,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire b2s_pkg::in_item_t in_data_i,
  output logic               q_push_o,
  output b2s_pkg::job_t      q_data_o,
  input  wire logic          q_full_i
);
  logic [5:0] dlen_q, klen_q;
  logic       in_msg_q;
  logic [5:0] dl, kl;

  always_comb begin
    dl = dlen_q;
    if (dl == 6'd0) dl = 6'd1;
    if (dl > 6'd32) dl = 6'd32;
    kl = (klen_q > 6'd32) ? 6'd32 : klen_q;
  end

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;
  always_comb begin
    q_data_o.data_word  = in_data_i.data_word;
    q_data_o.byte_count = (in_data_i.byte_count > 3'd4) ? 3'd4 : in_data_i.byte_count;
    q_data_o.last_item  = in_data_i.last_item;
    q_data_o.first      = !in_msg_q;
    q_data_o.digest_len = dl;
    q_data_o.key_len    = kl;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dlen_q   <= 6'd32;
      klen_q   <= 6'd0;
      in_msg_q <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_idx_i == 1'(b2s_pkg::RegDigestBytes)) dlen_q <= cfg_data_i;
      if (cfg_we_i && cfg_idx_i == 1'(b2s_pkg::RegKeyBytes)) klen_q <= cfg_data_i;
      if (q_push_o) in_msg_q <= !in_data_i.last_item;
    end
  end
endmodule
`default_nettype wire

/* design/b2s_fifo.sv */
// Two-entry queue between front end and back end.
// Depends on b2s_pkg.
`default_nettype none
module b2s_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire b2s_pkg::job_t data_i,
  output logic               full_o,
  output logic               valid_o,
  input  wire logic          pop_i,
  output b2s_pkg::job_t      data_o
);
  b2s_pkg::job_t mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= !wp_q;
      if (pop_i) rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end
endmodule
`default_nettype wire

/* design/b2s_back.sv */
// Back end: packs bytes into the block, runs the compression one G step a
// cycle, and emits digest words. Depends on b2s_pkg.
`default_nettype none
module b2s_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          q_valid_i,
  input  wire b2s_pkg::job_t q_data_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output b2s_pkg::out_item_t out_data_o
);
  typedef enum logic [2:0] {StIdle, StByte, StComp, StFin, StOut} state_e;

  state_e      state_q;
  logic [31:0] h_q [8];
  logic [31:0] m_q [16];
  logic [31:0] v_q [16];
  logic [6:0]  nbytes_q;
  logic [63:0] cnt_q;
  logic [5:0]  dlen_q;
  logic [2:0]  bi_q;
  logic [3:0]  rnd_q;
  logic [3:0]  g_q;      // G step 0..7; 8 marks the end of the last round
  logic        fin_q;
  logic [2:0]  oi_q;
  b2s_pkg::job_t job_q;
  logic        ov_q;
  b2s_pkg::out_item_t od_q;

  // One full G function per cycle.
  logic [3:0] ia, ib, ic, id;
  logic [31:0] a0, b0, c0, d0, a1, b1, c1, d1, a2, b2, c2, d2, mx, my;
  always_comb begin
    unique case (g_q[2:0])
      3'd0: begin ia = 4'd0; ib = 4'd4; ic = 4'd8;  id = 4'd12; end
      3'd1: begin ia = 4'd1; ib = 4'd5; ic = 4'd9;  id = 4'd13; end
      3'd2: begin ia = 4'd2; ib = 4'd6; ic = 4'd10; id = 4'd14; end
      3'd3: begin ia = 4'd3; ib = 4'd7; ic = 4'd11; id = 4'd15; end
      3'd4: begin ia = 4'd0; ib = 4'd5; ic = 4'd10; id = 4'd15; end
      3'd5: begin ia = 4'd1; ib = 4'd6; ic = 4'd11; id = 4'd12; end
      3'd6: begin ia = 4'd2; ib = 4'd7; ic = 4'd8;  id = 4'd13; end
      default: begin ia = 4'd3; ib = 4'd4; ic = 4'd9; id = 4'd14; end
    endcase
    mx = m_q[b2s_pkg::sigma(rnd_q, {g_q[2:0], 1'b0})];
    my = m_q[b2s_pkg::sigma(rnd_q, {g_q[2:0], 1'b1})];
    a0 = v_q[ia] + v_q[ib] + mx;
    d0 = v_q[id] ^ a0; d0 = {d0[15:0], d0[31:16]};
    c0 = v_q[ic] + d0;
    b0 = v_q[ib] ^ c0; b0 = {b0[11:0], b0[31:12]};
    a1 = a0 + b0 + my;
    d1 = d0 ^ a1; d1 = {d1[7:0], d1[31:8]};
    c1 = c0 + d1;
    b1 = b0 ^ c1; b1 = {b1[6:0], b1[31:7]};
    a2 = a1; b2 = b1; c2 = c1; d2 = d1;
  end

  logic [6:0]  bpos;
  logic [7:0]  bval;
  assign bpos = nbytes_q;
  assign bval = job_q.data_word[8*bi_q[1:0] +: 8];
  assign q_pop_o = (state_q == StIdle) && q_valid_i;
  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ov_q <= 1'b0;
      nbytes_q <= '0;
      cnt_q <= '0;
      dlen_q <= 6'd32;
    end else begin
      if (ov_q && !out_stall_i) ov_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (q_valid_i) begin
            job_q <= q_data_i;
            bi_q <= '0;
            if (q_data_i.first) begin
              dlen_q <= q_data_i.digest_len;
              for (int i = 0; i < 8; i++) h_q[i] <= b2s_pkg::iv_word(3'(i));
              h_q[0] <= b2s_pkg::iv_word(3'd0) ^ b2s_pkg::ParamBase ^
                        {18'd0, q_data_i.key_len, 2'd0, q_data_i.digest_len};
              for (int i = 0; i < 16; i++) m_q[i] <= '0;
              nbytes_q <= '0;
              cnt_q <= '0;
            end
            state_q <= StByte;
          end
        end
        StByte: begin
          if ({1'b0, bi_q} >= {1'b0, job_q.byte_count}) begin
            if (job_q.last_item) begin
              cnt_q <= cnt_q + 64'(nbytes_q);
              fin_q <= 1'b1;
              state_q <= StFin;
            end else state_q <= StIdle;
          end else if (bpos == 7'd64) begin
            cnt_q <= cnt_q + 64'd64;
            fin_q <= 1'b0;
            state_q <= StFin;
          end else begin
            m_q[bpos[5:2]][8*bpos[1:0] +: 8] <= bval;
            nbytes_q <= nbytes_q + 7'd1;
            bi_q <= bi_q + 3'd1;
          end
        end
        StFin: begin  // load working vector
          for (int i = 0; i < 8; i++) begin
            v_q[i] <= h_q[i];
            v_q[i+8] <= b2s_pkg::iv_word(3'(i));
          end
          v_q[12] <= b2s_pkg::iv_word(3'd4) ^ cnt_q[31:0];
          v_q[13] <= b2s_pkg::iv_word(3'd5) ^ cnt_q[63:32];
          v_q[14] <= b2s_pkg::iv_word(3'd6) ^ {32{fin_q}};
          rnd_q <= '0; g_q <= '0;
          state_q <= StComp;
        end
        StComp: begin
          if (g_q == 4'd8) begin
            for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] ^ v_q[i] ^ v_q[i+8];
            if (fin_q) begin
              oi_q <= '0;
              state_q <= StOut;
            end else begin
              for (int i = 0; i < 16; i++) m_q[i] <= '0;
              nbytes_q <= '0;
              state_q <= StByte;
            end
          end else begin
            v_q[ia] <= a2; v_q[ib] <= b2; v_q[ic] <= c2; v_q[id] <= d2;
            if (g_q == 4'd7) begin
              if (rnd_q == 4'd9) g_q <= 4'd8;
              else begin g_q <= '0; rnd_q <= rnd_q + 4'd1; end
            end else g_q <= g_q + 4'd1;
          end
        end
        StOut: begin
          if (!ov_q || !out_stall_i) begin
            logic [5:0] rem;
            rem = dlen_q - {1'b0, oi_q, 2'b00};
            ov_q <= 1'b1;
            od_q.word_index <= oi_q;
            od_q.last_word <= rem <= 6'd4;
            case (rem)
              6'd1: od_q.digest_word <= {24'd0, h_q[oi_q][7:0]};
              6'd2: od_q.digest_word <= {16'd0, h_q[oi_q][15:0]};
              6'd3: od_q.digest_word <= {8'd0, h_q[oi_q][23:0]};
              default: od_q.digest_word <= h_q[oi_q];
            endcase
            oi_q <= oi_q + 3'd1;
            if (rem <= 6'd4) state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

/* design/blake2s_hash_engine_unit.sv */
// Top level of the BLAKE2s hash engine: front end, queue and back end.
// Depends on b2s_pkg, b2s_front, b2s_fifo and b2s_back.
//
//  channel | direction | handshake            | payload
//  in      | to block  | in_valid_i/in_stall_o  | b2s_pkg::in_item_t
//  out     | from block| out_valid_o/out_stall_i| b2s_pkg::out_item_t
//  cfg     | to block  | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// A full block runs one G function per cycle, 80 steps, in the shared G
// unit, plus load and feed-forward. Digest words follow one a cycle unless
// stalled. Reset clears control state except the round, step, index and
// fin_q registers. A two-item queue lets the front end take items while
// the back end compresses or the output is stalled.
`default_nettype none
module blake2s_hash_engine_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [0:0]         cfg_idx_i,
  input  wire logic [5:0]         cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire b2s_pkg::in_item_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output b2s_pkg::out_item_t      out_data_o
);
  logic          push, full, qv, pop;
  b2s_pkg::job_t qin, qout;

  b2s_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .in_data_i,
    .q_push_o(push), .q_data_o(qin), .q_full_i(full)
  );

  b2s_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .data_i(qin), .full_o(full),
    .valid_o(qv), .pop_i(pop), .data_o(qout)
  );

  b2s_back u_back (
    .clk_i, .rst_ni, .q_valid_i(qv), .q_data_i(qout), .q_pop_o(pop),
    .out_valid_o, .out_stall_i, .out_data_o
  );

  // The queue never takes an item while full.
  assert property (@(posedge clk_i) disable iff (!rst_ni) full |-> !push)
    else $error("push into full queue");
  // The back end only pops a queue entry that is present.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> qv)
    else $error("pop from empty queue");
  // A stalled result item holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output changed");
endmodule
`default_nettype wire
